[rtl/tile_floor_height_query_assert.svh]
// assertion macros for the tile floor height query block
// used by rtl/tile_floor_height_query.sv; no other dependencies
`ifndef TILE_FLOOR_HEIGHT_QUERY_ASSERT_SVH
`define TILE_FLOOR_HEIGHT_QUERY_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TFHQ_ASSERT_SAME(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);
// next-cycle implication
`define TFHQ_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);
`else
`define TFHQ_ASSERT_SAME(lbl, clk, rst, cond, conseq, msg)
`define TFHQ_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg)
`endif

`endif

[rtl/tfhq_pkg.sv]
// shared types and constants for the tile floor height query block
// no dependencies
`timescale 1ns / 1ps

package tfhq_pkg;

  localparam int HEIGHT_W = 25;

  typedef enum logic [3:0] {
    KIND_SOLID   = 4'd0,
    KIND_OPEN    = 4'd1,
    KIND_DIAG_SE = 4'd2,
    KIND_DIAG_SW = 4'd3,
    KIND_DIAG_NW = 4'd4,
    KIND_DIAG_NE = 4'd5,
    KIND_SLOPE_N = 4'd6,
    KIND_SLOPE_S = 4'd7,
    KIND_SLOPE_E = 4'd8,
    KIND_SLOPE_W = 4'd9
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] floor_level;
    logic [15:0] ceiling_level;
    logic [7:0]  slope_rise;
  } tile_t;

endpackage

[rtl/tile_floor_height_query.sv]
// tile floor height query: tile store memory with read, evaluate and output stages
// depends on rtl/tfhq_pkg.sv and rtl/tile_floor_height_query_assert.svh
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   req     | req_valid, req_stall | action, x_pos, y_pos, tile_kind, floor_level,
//           |                      | ceiling_level, slope_rise
//   rsp     | rsp_valid, rsp_stall | height, bad_kind
//
// one transaction per cycle while req_stall is low; an accepted one passes the read stage, then the result register
// a single tile store port: a write transaction writes it, a query reads it
// a read always comes after the write of an earlier transaction, so it sees that write
// reset clears only the pipeline valid bits; tile contents stay undefined until written
// a stall on rsp holds the result register, and holds the read stage and stalls req once it is full
`timescale 1ns / 1ps
`include "tile_floor_height_query_assert.svh"

module tile_floor_height_query #(
  parameter int MAP_SIZE  = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          action,
  input  logic signed [15:0]            x_pos,
  input  logic signed [15:0]            y_pos,
  input  logic [3:0]                    tile_kind,
  input  logic [15:0]                   floor_level,
  input  logic [15:0]                   ceiling_level,
  input  logic [7:0]                    slope_rise,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [tfhq_pkg::HEIGHT_W-1:0] height,
  output logic                          bad_kind
);

  localparam int DEPTH   = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int TILE_W  = $clog2(MAP_SIZE);
  localparam int PROD_W  = 8 + FRAC_BITS;
  localparam int HW      = tfhq_pkg::HEIGHT_W;
  localparam logic [16:0]         SPAN       = 17'(MAP_SIZE) << FRAC_BITS;
  localparam logic [ADDR_W-1:0]   MAP_SIZE_A = ADDR_W'(MAP_SIZE);
  localparam logic [FRAC_BITS:0]  ONE_FIX    = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  tfhq_pkg::tile_t tile_mem [DEPTH];
  tfhq_pkg::tile_t rd_tile;
  tfhq_pkg::tile_t wr_tile;

  logic                 accept;
  logic                 advance;
  logic                 on_map;
  logic                 wr_en;
  logic                 rd_en;
  logic [TILE_W-1:0]    tx;
  logic [TILE_W-1:0]    ty;
  logic [ADDR_W-1:0]    addr;

  logic                 s1_valid;
  logic                 s1_query;
  logic [FRAC_BITS-1:0] s1_fx;
  logic [FRAC_BITS-1:0] s1_fy;

  logic [FRAC_BITS-1:0] sel_f;
  logic [FRAC_BITS:0]   frac_sum;
  logic [PROD_W-1:0]    prod;
  logic [HW-1:0]        fl;
  logic [HW-1:0]        ce;
  logic [HW-1:0]        top;
  logic [HW-1:0]        height_next;
  logic                 bad_kind_next;

  // handshake
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;

  // address decode
  assign on_map = !x_pos[15] && !y_pos[15] &&
                  ({2'b00, x_pos[14:0]} < SPAN) && ({2'b00, y_pos[14:0]} < SPAN);
  assign tx     = x_pos[FRAC_BITS +: TILE_W];
  assign ty     = y_pos[FRAC_BITS +: TILE_W];
  assign addr   = ADDR_W'(ty) * MAP_SIZE_A + ADDR_W'(tx);
  assign wr_en  = accept && !action && on_map;
  assign rd_en  = accept && action && on_map;

  always_comb begin
    wr_tile.kind          = tfhq_pkg::kind_t'(tile_kind);
    wr_tile.floor_level   = floor_level;
    wr_tile.ceiling_level = ceiling_level;
    wr_tile.slope_rise    = slope_rise;
  end

  // tile store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tile_mem[addr] <= wr_tile;
    end
    if (rd_en) begin
      rd_tile <= tile_mem[addr];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_query <= action && on_map;
      s1_fx    <= x_pos[FRAC_BITS-1:0];
      s1_fy    <= y_pos[FRAC_BITS-1:0];
    end
  end

  // evaluate stage
  always_comb begin
    case (rd_tile.kind)
      tfhq_pkg::KIND_SLOPE_E, tfhq_pkg::KIND_SLOPE_W: sel_f = s1_fx;
      default:                                        sel_f = s1_fy;
    endcase
    frac_sum = (FRAC_BITS + 1)'(s1_fx) + (FRAC_BITS + 1)'(s1_fy);
    prod     = PROD_W'(rd_tile.slope_rise) * PROD_W'(sel_f);
    fl       = HW'(rd_tile.floor_level) << FRAC_BITS;
    ce       = HW'(rd_tile.ceiling_level) << FRAC_BITS;
    top      = (HW'(rd_tile.floor_level) + HW'(rd_tile.slope_rise)) << FRAC_BITS;
  end

  always_comb begin
    height_next   = '0;
    bad_kind_next = 1'b0;
    if (s1_query) begin
      case (rd_tile.kind)
        tfhq_pkg::KIND_SOLID:   height_next = ce;
        tfhq_pkg::KIND_OPEN:    height_next = fl;
        tfhq_pkg::KIND_DIAG_SE: height_next = (s1_fx < s1_fy) ? ce : fl;
        tfhq_pkg::KIND_DIAG_SW: height_next = (frac_sum > ONE_FIX) ? ce : fl;
        tfhq_pkg::KIND_DIAG_NW: height_next = (s1_fx > s1_fy) ? ce : fl;
        tfhq_pkg::KIND_DIAG_NE: height_next = (frac_sum < ONE_FIX) ? ce : fl;
        tfhq_pkg::KIND_SLOPE_N: height_next = fl + HW'(prod);
        tfhq_pkg::KIND_SLOPE_S: height_next = top - HW'(prod);
        tfhq_pkg::KIND_SLOPE_E: height_next = fl + HW'(prod);
        tfhq_pkg::KIND_SLOPE_W: height_next = top - HW'(prod);
        default: begin
          height_next   = '0;
          bad_kind_next = 1'b1;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      height   <= height_next;
      bad_kind <= bad_kind_next;
    end
  end

  // checks
  `TFHQ_ASSERT_NEXT(a_write_gives_zero, clk, rst, s1_valid && !s1_query && advance, height == '0 && !bad_kind, "write or off-map transaction gave a nonzero result")
  `TFHQ_ASSERT_SAME(a_bad_kind_zero_height, clk, rst, rsp_valid && bad_kind, height == '0, "unknown kind result carries a height")
  `TFHQ_ASSERT_NEXT(a_full_accept_moves, clk, rst, accept && s1_valid, rsp_valid && s1_valid, "transaction accepted into a full read stage without moving it on")

endmodule
